>>> sv/epcc_pkg.sv
// Package for the Ethernet frame classifier with statistics counters.
// Types, protocol constants, counter and register indexes, used by all modules but epcc_fifo.
// No dependencies.
package epcc_pkg;

  localparam int unsigned MAX_FRAME_BYTES_DEF = 1518;
  localparam int unsigned COUNTER_BITS_DEF    = 32;
  localparam int unsigned NUM_COUNTERS        = 20;
  localparam int unsigned NUM_SLOTS           = 13;
  localparam int unsigned QUEUE_DEPTH         = 4;
  localparam int unsigned CFG_ADDR_W          = 5;
  localparam int unsigned CFG_DATA_W          = 32;
  localparam int unsigned PORT_W              = 16;
  localparam int unsigned IDX_W               = 5;
  localparam int unsigned VALUE_W             = 32;
  localparam int unsigned LEN_OUT_W           = 11;

  // Frame offsets of the captured header bytes, one per slot
  localparam logic [5:0] SLOT_OFFSET [NUM_SLOTS] = '{
    6'd12, 6'd13, 6'd20, 6'd21, 6'd23, 6'd34, 6'd35, 6'd36, 6'd37,
    6'd54, 6'd55, 6'd56, 6'd57
  };

  localparam int unsigned SLOT_ETYPE_HI = 0;   // offset 12
  localparam int unsigned SLOT_ETYPE_LO = 1;   // offset 13
  localparam int unsigned SLOT_B20      = 2;   // ARP opcode high / IPv6 next header
  localparam int unsigned SLOT_B21      = 3;   // ARP opcode low
  localparam int unsigned SLOT_B23      = 4;   // IPv4 protocol
  localparam int unsigned SLOT_V4_L4    = 5;   // offsets 34..37
  localparam int unsigned SLOT_V6_L4    = 9;   // offsets 54..57

  localparam logic [7:0] ETYPE_HI_IP    = 8'h08;
  localparam logic [7:0] ETYPE_LO_ARP   = 8'h06;
  localparam logic [7:0] ETYPE_LO_IPV4  = 8'h00;
  localparam logic [7:0] ETYPE_HI_IPV6  = 8'h86;
  localparam logic [7:0] ETYPE_LO_IPV6  = 8'hdd;
  localparam logic [7:0] ARP_OP_HI      = 8'h00;
  localparam logic [7:0] ARP_OP_REQ     = 8'h01;
  localparam logic [7:0] ARP_OP_REP     = 8'h02;
  localparam logic [7:0] PROTO_ICMP     = 8'h01;
  localparam logic [7:0] PROTO_TCP      = 8'h06;
  localparam logic [7:0] PROTO_UDP      = 8'h11;
  localparam logic [7:0] PROTO_ICMPV6   = 8'h3a;
  localparam logic [7:0] ICMP_ECHO_REQ  = 8'h08;
  localparam logic [7:0] ICMP_ECHO_REP  = 8'h00;
  localparam logic [7:0] ICMP6_ECHO_REQ = 8'h80;
  localparam logic [7:0] ICMP6_ECHO_REP = 8'h81;

  typedef enum logic [2:0] {
    LINK_OTHER, LINK_ARP_REQ, LINK_ARP_REP, LINK_IPV4, LINK_IPV6
  } link_t;

  typedef enum logic [2:0] {
    TRANS_NONE, TRANS_ICMP, TRANS_ICMPV6, TRANS_TCP, TRANS_UDP
  } trans_t;

  typedef enum logic [1:0] {
    ECHO_NONE, ECHO_REQ, ECHO_REP
  } echo_t;

  typedef enum logic [2:0] {
    APP_NONE, APP_HTTP, APP_DNS, APP_DHCP, APP_HTTPS
  } app_t;

  typedef struct packed {
    link_t  link;
    trans_t trans;
    echo_t  echo;
    app_t   app;
  } epcc_class_t;

  // Work handed from front to back; frame length travels alongside
  typedef struct packed {
    logic             is_read;
    logic [IDX_W-1:0] idx;
    epcc_class_t      cls;
  } epcc_job_t;

  typedef struct packed {
    logic                 result_kind;
    epcc_class_t          cls;
    logic [LEN_OUT_W-1:0] frame_length;
    logic [VALUE_W-1:0]   counter_value;
  } epcc_result_t;

  typedef struct packed {
    logic [PORT_W-1:0] http;
    logic [PORT_W-1:0] dns;
    logic [PORT_W-1:0] dhcp_cli;
    logic [PORT_W-1:0] dhcp_srv;
    logic [PORT_W-1:0] https;
  } epcc_cfg_t;

  localparam logic [2:0] REG_HTTP     = 3'd0;
  localparam logic [2:0] REG_DNS      = 3'd1;
  localparam logic [2:0] REG_DHCP_CLI = 3'd2;
  localparam logic [2:0] REG_DHCP_SRV = 3'd3;
  localparam logic [2:0] REG_HTTPS    = 3'd4;

  localparam logic [PORT_W-1:0] HTTP_PORT_RST     = 16'd80;
  localparam logic [PORT_W-1:0] DNS_PORT_RST      = 16'd53;
  localparam logic [PORT_W-1:0] DHCP_CLI_PORT_RST = 16'd68;
  localparam logic [PORT_W-1:0] DHCP_SRV_PORT_RST = 16'd67;
  localparam logic [PORT_W-1:0] HTTPS_PORT_RST    = 16'd443;

  localparam logic [IDX_W-1:0] CNT_PACKETS    = 5'd0;
  localparam logic [IDX_W-1:0] CNT_MIN        = 5'd1;
  localparam logic [IDX_W-1:0] CNT_MAX        = 5'd2;
  localparam logic [IDX_W-1:0] CNT_SUM        = 5'd3;
  localparam logic [IDX_W-1:0] CNT_IPV4       = 5'd4;
  localparam logic [IDX_W-1:0] CNT_IPV6       = 5'd5;
  localparam logic [IDX_W-1:0] CNT_ARP_REQ    = 5'd6;
  localparam logic [IDX_W-1:0] CNT_ARP_REP    = 5'd7;
  localparam logic [IDX_W-1:0] CNT_TCP        = 5'd8;
  localparam logic [IDX_W-1:0] CNT_UDP        = 5'd9;
  localparam logic [IDX_W-1:0] CNT_ICMP       = 5'd10;
  localparam logic [IDX_W-1:0] CNT_ICMP_REQ   = 5'd11;
  localparam logic [IDX_W-1:0] CNT_ICMP_REP   = 5'd12;
  localparam logic [IDX_W-1:0] CNT_ICMP6      = 5'd13;
  localparam logic [IDX_W-1:0] CNT_ICMP6_REQ  = 5'd14;
  localparam logic [IDX_W-1:0] CNT_ICMP6_REP  = 5'd15;
  localparam logic [IDX_W-1:0] CNT_HTTP       = 5'd16;
  localparam logic [IDX_W-1:0] CNT_DNS        = 5'd17;
  localparam logic [IDX_W-1:0] CNT_DHCP       = 5'd18;
  localparam logic [IDX_W-1:0] CNT_HTTPS      = 5'd19;

endpackage

>>> sv/epcc_fifo.sv
// Small register queue used between front, back and the result port.
// Depends on nothing; DEPTH must be a power of two, at least 2.
module epcc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full  = (count_r == CNT_W'(DEPTH));
  assign empty = (count_r == '0);
  assign dout  = mem_r[rd_ptr_r];

  always_comb begin
    do_push    = push && !full;
    do_pop     = pop && !empty;
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

>>> sv/epcc_front.sv
// Front end: takes frame bytes and read requests, captures header bytes,
// classifies each frame at its last byte. Depends on epcc_pkg.
module epcc_front #(
  parameter int unsigned MAX_FRAME_BYTES = 1518,
  parameter int unsigned POS_W           = 11
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  logic                     full,
  input  logic                     kind,
  input  logic [7:0]               data_byte,
  input  logic                     last,
  input  logic [epcc_pkg::IDX_W-1:0] counter_index,
  input  epcc_pkg::epcc_cfg_t      cfg,
  output logic                     job_push,
  output epcc_pkg::epcc_job_t      job,
  output logic [POS_W-1:0]         job_len
);
  import epcc_pkg::*;

  logic [7:0]       hdr_r   [NUM_SLOTS];
  logic [7:0]       hdr_nxt [NUM_SLOTS];
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             accept, byte_acc, below_max;
  logic             arp, v4, v6;
  logic [PORT_W-1:0] src_port, dst_port;
  epcc_class_t      cls;

  always_comb begin
    accept    = push && !full;
    byte_acc  = accept && !kind;
    below_max = (pos_r < POS_W'(MAX_FRAME_BYTES));
    hdr_nxt   = hdr_r;
    pos_nxt   = pos_r;
    if (byte_acc && below_max) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (pos_r == POS_W'(SLOT_OFFSET[i])) begin
          hdr_nxt[i] = data_byte;
        end
      end
      pos_nxt = pos_r + 1'b1;
    end
    if (byte_acc && last) begin
      pos_nxt = '0;
    end
    // bytes past the maximum are not counted
    job_len = below_max ? pos_r + 1'b1 : pos_r;
  end

  // Classification works on the header including the byte taken this cycle
  always_comb begin
    arp = (hdr_nxt[SLOT_ETYPE_HI] == ETYPE_HI_IP) && (hdr_nxt[SLOT_ETYPE_LO] == ETYPE_LO_ARP);
    v4  = (hdr_nxt[SLOT_ETYPE_HI] == ETYPE_HI_IP) && (hdr_nxt[SLOT_ETYPE_LO] == ETYPE_LO_IPV4);
    v6  = (hdr_nxt[SLOT_ETYPE_HI] == ETYPE_HI_IPV6)
          && (hdr_nxt[SLOT_ETYPE_LO] == ETYPE_LO_IPV6);
    cls = '0;

    if (arp && hdr_nxt[SLOT_B20] == ARP_OP_HI && hdr_nxt[SLOT_B21] == ARP_OP_REQ) begin
      cls.link = LINK_ARP_REQ;
    end else if (arp && hdr_nxt[SLOT_B20] == ARP_OP_HI && hdr_nxt[SLOT_B21] == ARP_OP_REP) begin
      cls.link = LINK_ARP_REP;
    end else if (v4) begin
      cls.link = LINK_IPV4;
    end else if (v6) begin
      cls.link = LINK_IPV6;
    end

    if (v4 && hdr_nxt[SLOT_B23] == PROTO_ICMP) begin
      cls.trans = TRANS_ICMP;
      if (hdr_nxt[SLOT_V4_L4] == ICMP_ECHO_REQ) begin
        cls.echo = ECHO_REQ;
      end else if (hdr_nxt[SLOT_V4_L4] == ICMP_ECHO_REP) begin
        cls.echo = ECHO_REP;
      end
    end else if (v6 && hdr_nxt[SLOT_B20] == PROTO_ICMPV6) begin
      cls.trans = TRANS_ICMPV6;
      if (hdr_nxt[SLOT_V6_L4] == ICMP6_ECHO_REQ) begin
        cls.echo = ECHO_REQ;
      end else if (hdr_nxt[SLOT_V6_L4] == ICMP6_ECHO_REP) begin
        cls.echo = ECHO_REP;
      end
    end else if ((v4 && hdr_nxt[SLOT_B23] == PROTO_TCP)
                 || (v6 && hdr_nxt[SLOT_B20] == PROTO_TCP)) begin
      cls.trans = TRANS_TCP;
    end else if ((v4 && hdr_nxt[SLOT_B23] == PROTO_UDP)
                 || (v6 && hdr_nxt[SLOT_B20] == PROTO_UDP)) begin
      cls.trans = TRANS_UDP;
    end

    // L4 ports sit at 34 for IPv4, otherwise at 54
    if (v4) begin
      src_port = {hdr_nxt[SLOT_V4_L4], hdr_nxt[SLOT_V4_L4 + 1]};
      dst_port = {hdr_nxt[SLOT_V4_L4 + 2], hdr_nxt[SLOT_V4_L4 + 3]};
    end else begin
      src_port = {hdr_nxt[SLOT_V6_L4], hdr_nxt[SLOT_V6_L4 + 1]};
      dst_port = {hdr_nxt[SLOT_V6_L4 + 2], hdr_nxt[SLOT_V6_L4 + 3]};
    end

    if (cls.trans == TRANS_TCP && (src_port == cfg.http || dst_port == cfg.http)) begin
      cls.app = APP_HTTP;
    end else if (cls.trans == TRANS_UDP && (src_port == cfg.dns || dst_port == cfg.dns)) begin
      cls.app = APP_DNS;
    end else if (cls.trans == TRANS_UDP
                 && ((src_port == cfg.dhcp_cli && dst_port == cfg.dhcp_srv)
                     || (src_port == cfg.dhcp_srv && dst_port == cfg.dhcp_cli))) begin
      cls.app = APP_DHCP;
    end else if (cls.trans == TRANS_TCP
                 && (src_port == cfg.https || dst_port == cfg.https)) begin
      cls.app = APP_HTTPS;
    end
  end

  always_comb begin
    job_push    = accept && (kind || last);
    job.is_read = kind;
    job.idx     = counter_index;
    job.cls     = cls;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      hdr_r <= '{default: '0};
    end else begin
      pos_r <= pos_nxt;
      hdr_r <= hdr_nxt;
    end
  end

  a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(MAX_FRAME_BYTES))
    else $error("frame byte position beyond maximum frame size");

  a_last_clears_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (byte_acc && last) |=> (pos_r == '0))
    else $error("byte position not cleared after frame end");

  a_read_keeps_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && kind) |=> $stable(pos_r))
    else $error("counter read disturbed the frame in progress");

endmodule

>>> sv/epcc_back.sv
// Back end: applies classified frames to the statistics counters and
// serves counter reads, in queue order. Depends on epcc_pkg.
module epcc_back #(
  parameter int unsigned MAX_FRAME_BYTES = 1518,
  parameter int unsigned COUNTER_BITS    = 32,
  parameter int unsigned POS_W           = 11
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   job_valid,
  input  epcc_pkg::epcc_job_t    job,
  input  logic [POS_W-1:0]       job_len,
  output logic                   job_pop,
  input  logic                   res_full,
  output logic                   res_push,
  output epcc_pkg::epcc_result_t res
);
  import epcc_pkg::*;

  logic [COUNTER_BITS-1:0] cnt_r   [NUM_COUNTERS];
  logic [COUNTER_BITS-1:0] cnt_nxt [NUM_COUNTERS];
  logic [COUNTER_BITS-1:0] len_ext;
  logic [63:0]             rd_wide;
  logic                    frame_upd;

  assign job_pop   = job_valid && !res_full;
  assign res_push  = job_pop;
  assign frame_upd = job_pop && !job.is_read;
  assign len_ext   = COUNTER_BITS'(job_len);

  always_comb begin
    cnt_nxt = cnt_r;
    if (frame_upd) begin
      cnt_nxt[CNT_PACKETS] = cnt_r[CNT_PACKETS] + 1'b1;
      if (len_ext < cnt_r[CNT_MIN]) begin
        cnt_nxt[CNT_MIN] = len_ext;
      end
      if (len_ext > cnt_r[CNT_MAX]) begin
        cnt_nxt[CNT_MAX] = len_ext;
      end
      cnt_nxt[CNT_SUM] = cnt_r[CNT_SUM] + len_ext;

      unique case (job.cls.link)
        LINK_ARP_REQ: cnt_nxt[CNT_ARP_REQ] = cnt_r[CNT_ARP_REQ] + 1'b1;
        LINK_ARP_REP: cnt_nxt[CNT_ARP_REP] = cnt_r[CNT_ARP_REP] + 1'b1;
        LINK_IPV4:    cnt_nxt[CNT_IPV4]    = cnt_r[CNT_IPV4] + 1'b1;
        LINK_IPV6:    cnt_nxt[CNT_IPV6]    = cnt_r[CNT_IPV6] + 1'b1;
        default: ;
      endcase

      unique case (job.cls.trans)
        TRANS_ICMP: begin
          cnt_nxt[CNT_ICMP] = cnt_r[CNT_ICMP] + 1'b1;
          if (job.cls.echo == ECHO_REQ) begin
            cnt_nxt[CNT_ICMP_REQ] = cnt_r[CNT_ICMP_REQ] + 1'b1;
          end else if (job.cls.echo == ECHO_REP) begin
            cnt_nxt[CNT_ICMP_REP] = cnt_r[CNT_ICMP_REP] + 1'b1;
          end
        end
        TRANS_ICMPV6: begin
          cnt_nxt[CNT_ICMP6] = cnt_r[CNT_ICMP6] + 1'b1;
          if (job.cls.echo == ECHO_REQ) begin
            cnt_nxt[CNT_ICMP6_REQ] = cnt_r[CNT_ICMP6_REQ] + 1'b1;
          end else if (job.cls.echo == ECHO_REP) begin
            cnt_nxt[CNT_ICMP6_REP] = cnt_r[CNT_ICMP6_REP] + 1'b1;
          end
        end
        TRANS_TCP: cnt_nxt[CNT_TCP] = cnt_r[CNT_TCP] + 1'b1;
        TRANS_UDP: cnt_nxt[CNT_UDP] = cnt_r[CNT_UDP] + 1'b1;
        default: ;
      endcase

      unique case (job.cls.app)
        APP_HTTP:  cnt_nxt[CNT_HTTP]  = cnt_r[CNT_HTTP] + 1'b1;
        APP_DNS:   cnt_nxt[CNT_DNS]   = cnt_r[CNT_DNS] + 1'b1;
        APP_DHCP:  cnt_nxt[CNT_DHCP]  = cnt_r[CNT_DHCP] + 1'b1;
        APP_HTTPS: cnt_nxt[CNT_HTTPS] = cnt_r[CNT_HTTPS] + 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    rd_wide = '0;
    if (job.idx < IDX_W'(NUM_COUNTERS)) begin
      rd_wide = 64'(cnt_r[job.idx]);
    end
    res = '0;
    if (job.is_read) begin
      res.result_kind   = 1'b1;
      res.counter_value = rd_wide[VALUE_W-1:0];
    end else begin
      res.cls          = job.cls;
      res.frame_length = LEN_OUT_W'(job_len);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '{CNT_MIN: COUNTER_BITS'(MAX_FRAME_BYTES), default: '0};
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r[CNT_PACKETS] != '0) |-> (cnt_r[CNT_MIN] <= cnt_r[CNT_MAX]))
    else $error("minimum frame length above maximum");

  a_min_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[CNT_MIN] <= COUNTER_BITS'(MAX_FRAME_BYTES))
    else $error("minimum frame length above maximum frame size");

  a_read_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    (job_pop && job.is_read) |=> $stable(cnt_r[CNT_PACKETS]))
    else $error("counter read changed the packet count");

endmodule

>>> sv/ethernet_packet_classify_count.sv
// Top level of the Ethernet frame classifier with statistics counters.
// Instantiates epcc_front, epcc_back and two epcc_fifo queues; uses epcc_pkg.
//
// Usage:
//   Input queue (push/full): one item per transfer, either a frame byte
//   (in_kind 0, in_last on the final byte) or a counter read (in_kind 1,
//   in_counter_index). Items are taken one per cycle while full is low.
//   Result queue (empty/pop): one result per frame end or read, in input order;
//   the oldest result stands on the out_ ports while empty is low.
//   Configuration: APB write of the five port-number registers at 0x0..0x10,
//   while the block is idle; pready is always high, reads return the value.
// Timing:
//   Throughput is one item per cycle while full is low. A frame end or read is
//   classified in the cycle it is taken, sits in a four-entry job queue, and the
//   counter unit retires one job per cycle unless the result queue is full, and
//   queues its result for the out_ ports. Other bytes produce nothing.
// Reset (rst_n low, synchronous): queues empty, counters zero except the
//   minimum length (maximum frame size), header bytes zero, ports at defaults.
// Stall: when pop is held off the result queue fills, then the job queue,
//   then full rises and input is held off; nothing is lost.
module ethernet_packet_classify_count #(
  parameter int unsigned MAX_FRAME_BYTES = epcc_pkg::MAX_FRAME_BYTES_DEF,
  parameter int unsigned COUNTER_BITS    = epcc_pkg::COUNTER_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             push,
  output logic                             full,
  input  logic                             in_kind,
  input  logic [7:0]                       in_data_byte,
  input  logic                             in_last,
  input  logic [epcc_pkg::IDX_W-1:0]       in_counter_index,
  output logic                             empty,
  input  logic                             pop,
  output logic                             out_result_kind,
  output logic [2:0]                       out_link_class,
  output logic [2:0]                       out_transport_class,
  output logic [1:0]                       out_echo_class,
  output logic [2:0]                       out_application_class,
  output logic [epcc_pkg::LEN_OUT_W-1:0]   out_frame_length,
  output logic [epcc_pkg::VALUE_W-1:0]     out_counter_value,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [epcc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [epcc_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [epcc_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import epcc_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int unsigned JOB_W = $bits(epcc_job_t) + POS_W;
  localparam int unsigned RES_W = $bits(epcc_result_t);

  epcc_cfg_t        cfg_r, cfg_nxt;
  logic             cfg_wr;
  logic [2:0]       reg_sel;

  logic             job_push, job_full, job_empty, job_pop;
  epcc_job_t        job_in, job_out;
  logic [POS_W-1:0] len_in, len_out;
  logic             res_push, res_full;
  epcc_result_t     res_in, res_out;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr) begin
      unique case (reg_sel)
        REG_HTTP:     cfg_nxt.http     = pwdata[PORT_W-1:0];
        REG_DNS:      cfg_nxt.dns      = pwdata[PORT_W-1:0];
        REG_DHCP_CLI: cfg_nxt.dhcp_cli = pwdata[PORT_W-1:0];
        REG_DHCP_SRV: cfg_nxt.dhcp_srv = pwdata[PORT_W-1:0];
        REG_HTTPS:    cfg_nxt.https    = pwdata[PORT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_HTTP:     prdata = CFG_DATA_W'(cfg_r.http);
      REG_DNS:      prdata = CFG_DATA_W'(cfg_r.dns);
      REG_DHCP_CLI: prdata = CFG_DATA_W'(cfg_r.dhcp_cli);
      REG_DHCP_SRV: prdata = CFG_DATA_W'(cfg_r.dhcp_srv);
      REG_HTTPS:    prdata = CFG_DATA_W'(cfg_r.https);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{http:     HTTP_PORT_RST,
                 dns:      DNS_PORT_RST,
                 dhcp_cli: DHCP_CLI_PORT_RST,
                 dhcp_srv: DHCP_SRV_PORT_RST,
                 https:    HTTPS_PORT_RST};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign full = job_full;

  epcc_front #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .POS_W           (POS_W)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (job_full),
    .kind          (in_kind),
    .data_byte     (in_data_byte),
    .last          (in_last),
    .counter_index (in_counter_index),
    .cfg           (cfg_r),
    .job_push      (job_push),
    .job           (job_in),
    .job_len       (len_in)
  );

  epcc_fifo #(
    .WIDTH (JOB_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   ({job_in, len_in}),
    .full  (job_full),
    .pop   (job_pop),
    .dout  ({job_out, len_out}),
    .empty (job_empty)
  );

  epcc_back #(
    .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
    .COUNTER_BITS    (COUNTER_BITS),
    .POS_W           (POS_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!job_empty),
    .job       (job_out),
    .job_len   (len_out),
    .job_pop   (job_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  epcc_fifo #(
    .WIDTH (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_out),
    .empty (empty)
  );

  assign out_result_kind       = res_out.result_kind;
  assign out_link_class        = res_out.cls.link;
  assign out_transport_class   = res_out.cls.trans;
  assign out_echo_class        = res_out.cls.echo;
  assign out_application_class = res_out.cls.app;
  assign out_frame_length      = res_out.frame_length;
  assign out_counter_value     = res_out.counter_value;

endmodule
